@@ sv/pta_pkg.sv @@
// shared types, constants and arithmetic helpers for the pan/tilt point transform
package pta_pkg;

  localparam int RW = 20;
  localparam int IW = 10;
  localparam int CW = 16;
  localparam int INCW = 12;
  localparam int OW = 21;
  localparam int ANGW = 24;
  localparam int TW = 19;
  localparam int XW = 38;
  localparam int YCW = 39;
  localparam int PW = 60;
  localparam int CIW = 4;
  localparam int CORDIC_STEPS = 16;
  localparam int DEF_MAX_SAMPLES = 1024;

  localparam int PI_Q13 = 25736;
  localparam int HALF_PI_Q13 = 12868;
  localparam int TWO_PI_Q13 = 51472;
  localparam int CORDIC_X0 = 39797;

  localparam logic [CIW-1:0] REG_PAN = 4'd0;
  localparam logic [CIW-1:0] REG_TILT = 4'd1;
  localparam logic [CIW-1:0] REG_INC = 4'd2;
  localparam logic [CIW-1:0] REG_START = 4'd3;
  localparam logic [CIW-1:0] REG_TILT_ARM = 4'd4;
  localparam logic [CIW-1:0] REG_PAN_ARM = 4'd5;
  localparam logic [CIW-1:0] REG_BASE = 4'd6;
  localparam logic [CIW-1:0] REG_SHIFT = 4'd7;

  localparam logic signed [CW-1:0] RST_PAN = 16'sd0;
  localparam logic signed [CW-1:0] RST_TILT = 16'sd0;
  localparam logic [INCW-1:0] RST_INC = 12'd50;
  localparam logic signed [CW-1:0] RST_START = -16'sd17154;
  localparam logic [CW-1:0] RST_TILT_ARM = 16'd450;
  localparam logic [CW-1:0] RST_PAN_ARM = 16'd400;
  localparam logic [CW-1:0] RST_BASE = 16'd1140;
  localparam logic [CW-1:0] RST_SHIFT = 16'd285;

  localparam logic signed [PW-1:0] HALF16 = PW'(64'sd32768);
  localparam logic signed [PW-1:0] HALF32 = PW'(64'sd2147483648);

  typedef struct packed {
    logic signed [TW-1:0] z;
    logic                 neg;
  } angle_t;

  typedef struct packed {
    logic signed [TW-1:0] c;
    logic signed [TW-1:0] s;
  } trig_t;

  function automatic logic signed [TW-1:0] atan_q16(input int i);
    logic signed [TW-1:0] v;
    case (i)
      0: v = 19'sd51472;
      1: v = 19'sd30386;
      2: v = 19'sd16055;
      3: v = 19'sd8150;
      4: v = 19'sd4091;
      5: v = 19'sd2047;
      6: v = 19'sd1024;
      7: v = 19'sd512;
      8: v = 19'sd256;
      9: v = 19'sd128;
      10: v = 19'sd64;
      11: v = 19'sd32;
      12: v = 19'sd16;
      13: v = 19'sd8;
      14: v = 19'sd4;
      15: v = 19'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // brings an angle in (-2pi, 2pi) to [-pi/2, pi/2] at Q16 with a sign flip flag
  function automatic angle_t fold(input logic signed [ANGW-1:0] a_in);
    logic signed [ANGW-1:0] a;
    angle_t res;
    a = a_in;
    res.neg = 1'b0;
    if (a >= ANGW'(PI_Q13)) begin
      a = a - ANGW'(TWO_PI_Q13);
    end else if (a < -ANGW'(PI_Q13)) begin
      a = a + ANGW'(TWO_PI_Q13);
    end
    if (a > ANGW'(HALF_PI_Q13)) begin
      a = a - ANGW'(PI_Q13);
      res.neg = 1'b1;
    end else if (a < -ANGW'(HALF_PI_Q13)) begin
      a = a + ANGW'(PI_Q13);
      res.neg = 1'b1;
    end
    res.z = TW'(a <<< 3);
    return res;
  endfunction

  function automatic logic signed [PW-1:0] rnd16(input logic signed [PW-1:0] v);
    return (v + HALF16) >>> 16;
  endfunction

  // round the q32 sum to an integer, add the offset and clamp to the output range
  function automatic logic signed [OW-1:0] finish(input logic signed [PW-1:0] s,
                                                  input logic signed [CW+1:0] off);
    logic signed [PW-1:0] t;
    logic signed [PW-31:0] v;
    logic signed [OW-1:0] res;
    t = (s + HALF32) >>> 32;
    v = (PW-30)'(t) + (PW-30)'(off);
    if (v < -(PW-30)'(1048576)) begin
      res = -21'sd1048576;
    end else if (v > (PW-30)'(1048575)) begin
      res = 21'sd1048575;
    end else begin
      res = OW'(v);
    end
    return res;
  endfunction

endpackage

@@ sv/pan_tilt_lidar_point_transform_core.sv @@
// top level: lidar sample to pan/tilt mounted cartesian point
//
// channel  direction  handshake              payload
// in       sink       in_valid / in_ready    range_distance, sample_index
// out      source     out_valid / out_ready  point_x, point_y, point_z
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one transaction per cycle sustained while the output register is not held
// the pipeline depth comes from the 16-stage cordic plus index, angle and product stages
// the whole pipeline holds when the output register is full and not taken
// rst clears valid bits and loads register defaults; cfg is always ready
module pan_tilt_lidar_point_transform_core #(
  parameter int MAX_SAMPLES = pta_pkg::DEF_MAX_SAMPLES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pta_pkg::RW-1:0]         range_distance,
  input  logic [pta_pkg::IW-1:0]         sample_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [pta_pkg::OW-1:0]  point_x,
  output logic signed [pta_pkg::OW-1:0]  point_y,
  output logic signed [pta_pkg::OW-1:0]  point_z,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pta_pkg::CIW-1:0]        cfg_index,
  input  logic [pta_pkg::CW-1:0]         cfg_data
);
  import pta_pkg::*;

  localparam int NV = 5 + CORDIC_STEPS + 7;
  localparam int MODW = IW + 8;

  logic signed [CW-1:0] pan_angle, tilt_angle, beam_origin;
  logic [INCW-1:0] beam_step;
  logic [CW-1:0] tilt_arm_offset, pan_arm_offset, base_height, lateral_shift;

  logic [NV-1:0] vld;
  logic en;

  assign cfg_ready = 1'b1;
  assign en = !vld[NV-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[NV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      pan_angle <= RST_PAN;
      tilt_angle <= RST_TILT;
      beam_step <= RST_INC;
      beam_origin <= RST_START;
      tilt_arm_offset <= RST_TILT_ARM;
      pan_arm_offset <= RST_PAN_ARM;
      base_height <= RST_BASE;
      lateral_shift <= RST_SHIFT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PAN: pan_angle <= cfg_data;
        REG_TILT: tilt_angle <= cfg_data;
        REG_INC: beam_step <= cfg_data[INCW-1:0];
        REG_START: beam_origin <= cfg_data;
        REG_TILT_ARM: tilt_arm_offset <= cfg_data;
        REG_PAN_ARM: pan_arm_offset <= cfg_data;
        REG_BASE: base_height <= cfg_data;
        REG_SHIFT: lateral_shift <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NV-2:0], in_valid};
    end
  end

  // index and beam angle stages
  logic [RW-1:0] r_a, r_b, r_c, r_d, r_e;
  logic [IW-1:0] idx_a, idx_b, idx_next;
  logic [IW+INCW-1:0] prod_c;
  logic signed [ANGW-1:0] beam_d, beam_next, beam_e;
  angle_t ang_b_e, ang_p_e, ang_t_e;

  always_comb begin
    logic [MODW-1:0] m;
    m = MODW'(idx_a);
    for (int k = 5; k >= 0; k--) begin
      if (m >= MODW'(MAX_SAMPLES << k)) begin
        m = m - MODW'(MAX_SAMPLES << k);
      end
    end
    idx_next = IW'(m);
  end

  always_comb begin
    logic signed [ANGW-1:0] b;
    b = ANGW'(beam_origin) + ANGW'(prod_c);
    if (b < 0) begin
      b = b + ANGW'(TWO_PI_Q13);
    end
    for (int k = 6; k >= 4; k--) begin
      if (b >= ANGW'(TWO_PI_Q13 << k)) begin
        b = b - ANGW'(TWO_PI_Q13 << k);
      end
    end
    beam_next = b;
  end

  always_comb begin
    logic signed [ANGW-1:0] b;
    b = beam_d;
    for (int k = 3; k >= 0; k--) begin
      if (b >= ANGW'(TWO_PI_Q13 << k)) begin
        b = b - ANGW'(TWO_PI_Q13 << k);
      end
    end
    beam_e = b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_a <= range_distance;
      idx_a <= sample_index;
      r_b <= r_a;
      idx_b <= idx_next;
      r_c <= r_b;
      prod_c <= (IW+INCW)'(idx_b) * (IW+INCW)'(beam_step);
      r_d <= r_c;
      beam_d <= beam_next;
      r_e <= r_d;
      ang_b_e <= fold(beam_e);
      ang_p_e <= fold(ANGW'(pan_angle));
      ang_t_e <= fold(ANGW'(tilt_angle));
    end
  end

  // trig of beam, pan and tilt
  trig_t tb, tp, tt;
  logic [RW-1:0] r_dl [CORDIC_STEPS];

  pta_cordic u_cordic_beam (.clk(clk), .en(en), .ang(ang_b_e), .trig(tb));
  pta_cordic u_cordic_pan  (.clk(clk), .en(en), .ang(ang_p_e), .trig(tp));
  pta_cordic u_cordic_tilt (.clk(clk), .en(en), .ang(ang_t_e), .trig(tt));

  always_ff @(posedge clk) begin
    if (en) begin
      r_dl[0] <= r_e;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
        r_dl[i] <= r_dl[i-1];
      end
    end
  end

  // product and sum stages
  logic signed [XW-1:0] xx1, yy1;
  logic signed [PW-1:0] a1_1, a2_1, l2sp1, l2cp1, l1ct1;
  trig_t tp1, tt1;

  logic signed [PW-1:0] xxcp_l2, xxcp_h2, xxsp_l2, xxsp_h2, yyst_l2, yyst_h2, yyct_l2, yyct_h2;
  logic signed [PW-1:0] r1_2, r2_2, l2sp2, l2cp2, l1ct2;
  trig_t tp2, tt2;

  logic signed [PW-1:0] xxcp3, xxsp3, yyst3, r1st3, r2st3, l2sp3, l2cp3, l1ct3;
  logic signed [YCW-1:0] yct3;
  trig_t tp3;

  logic signed [PW-1:0] ysp_l4, ysp_h4, ycp_l4, ycp_h4;
  logic signed [PW-1:0] xxcp4, xxsp4, yyst4, r1st4, r2st4, l2sp4, l2cp4, l1ct4;

  logic signed [PW-1:0] yctsp5, yctcp5, xxcp5, xxsp5, yyst5, r1st5, r2st5, l2sp5, l2cp5, l1ct5;
  logic signed [PW-1:0] sx6, sy6, sz6;
  logic signed [PW-1:0] yyct3;

  assign yyct3 = (yyct_h2 <<< 20) + yyct_l2;

  always_ff @(posedge clk) begin
    if (en) begin
      xx1 <= XW'($signed({1'b0, r_dl[CORDIC_STEPS-1]}) * tb.c);
      yy1 <= XW'($signed({1'b0, r_dl[CORDIC_STEPS-1]}) * tb.s);
      a1_1 <= PW'($signed({1'b0, tilt_arm_offset}) * tp.s);
      a2_1 <= PW'($signed({1'b0, tilt_arm_offset}) * tp.c);
      l2sp1 <= PW'($signed({1'b0, pan_arm_offset}) * tp.s);
      l2cp1 <= PW'($signed({1'b0, pan_arm_offset}) * tp.c);
      l1ct1 <= PW'($signed({1'b0, tilt_arm_offset}) * tt.c);
      tp1 <= tp;
      tt1 <= tt;

      xxcp_l2 <= PW'($signed({1'b0, xx1[19:0]}) * tp1.c);
      xxcp_h2 <= PW'($signed(xx1[XW-1:20]) * tp1.c);
      xxsp_l2 <= PW'($signed({1'b0, xx1[19:0]}) * tp1.s);
      xxsp_h2 <= PW'($signed(xx1[XW-1:20]) * tp1.s);
      yyst_l2 <= PW'($signed({1'b0, yy1[19:0]}) * tt1.s);
      yyst_h2 <= PW'($signed(yy1[XW-1:20]) * tt1.s);
      yyct_l2 <= PW'($signed({1'b0, yy1[19:0]}) * tt1.c);
      yyct_h2 <= PW'($signed(yy1[XW-1:20]) * tt1.c);
      r1_2 <= rnd16(a1_1);
      r2_2 <= rnd16(a2_1);
      l2sp2 <= l2sp1;
      l2cp2 <= l2cp1;
      l1ct2 <= l1ct1;
      tp2 <= tp1;
      tt2 <= tt1;

      xxcp3 <= (xxcp_h2 <<< 20) + xxcp_l2;
      xxsp3 <= (xxsp_h2 <<< 20) + xxsp_l2;
      yyst3 <= (yyst_h2 <<< 20) + yyst_l2;
      yct3 <= YCW'(rnd16(yyct3));
      r1st3 <= PW'($signed(r1_2[TW-1:0]) * tt2.s);
      r2st3 <= PW'($signed(r2_2[TW-1:0]) * tt2.s);
      l2sp3 <= l2sp2;
      l2cp3 <= l2cp2;
      l1ct3 <= l1ct2;
      tp3 <= tp2;

      ysp_l4 <= PW'($signed({1'b0, yct3[19:0]}) * tp3.s);
      ysp_h4 <= PW'($signed(yct3[YCW-1:20]) * tp3.s);
      ycp_l4 <= PW'($signed({1'b0, yct3[19:0]}) * tp3.c);
      ycp_h4 <= PW'($signed(yct3[YCW-1:20]) * tp3.c);
      xxcp4 <= xxcp3;
      xxsp4 <= xxsp3;
      yyst4 <= yyst3;
      r1st4 <= r1st3;
      r2st4 <= r2st3;
      l2sp4 <= l2sp3;
      l2cp4 <= l2cp3;
      l1ct4 <= l1ct3;

      yctsp5 <= (ysp_h4 <<< 20) + ysp_l4;
      yctcp5 <= (ycp_h4 <<< 20) + ycp_l4;
      xxcp5 <= xxcp4;
      xxsp5 <= xxsp4;
      yyst5 <= yyst4;
      r1st5 <= r1st4;
      r2st5 <= r2st4;
      l2sp5 <= l2sp4;
      l2cp5 <= l2cp4;
      l1ct5 <= l1ct4;

      sx6 <= xxcp5 - yctsp5 + r1st5 + (l2sp5 <<< 16);
      sy6 <= xxsp5 + yctcp5 - r2st5 + (l2cp5 <<< 16);
      sz6 <= yyst5 + (l1ct5 <<< 16);

      point_x <= finish(sx6, '0);
      point_y <= finish(sy6, -$signed({2'b00, lateral_shift}));
      point_z <= finish(sz6, $signed({2'b00, base_height}));
    end
  end

  // pipeline hold and shift
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> vld == $past(vld))
    else $error("valid bits moved during a stall");

  a_shift: assert property (@(posedge clk) disable iff (rst)
    en |=> vld[NV-1:1] == $past(vld[NV-2:0]))
    else $error("valid bit lost or duplicated in the pipeline");

  a_reset: assert property (@(posedge clk)
    $fell(rst) |-> vld == '0)
    else $error("pipeline not empty after reset");

endmodule

@@ sv/pta_cordic.sv @@
// pipelined rotation-mode cordic, one iteration per register stage
module pta_cordic (
  input  logic             clk,
  input  logic             en,
  input  pta_pkg::angle_t  ang,
  output pta_pkg::trig_t   trig
);
  import pta_pkg::*;

  logic signed [TW-1:0] xq [CORDIC_STEPS];
  logic signed [TW-1:0] yq [CORDIC_STEPS];
  logic signed [TW-1:0] zq [CORDIC_STEPS];
  logic                 nq [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [TW-1:0] xi, yi, zi;
    logic                 ni;
    if (i == 0) begin : g_first
      assign xi = TW'(CORDIC_X0);
      assign yi = '0;
      assign zi = ang.z;
      assign ni = ang.neg;
    end else begin : g_next
      assign xi = xq[i-1];
      assign yi = yq[i-1];
      assign zi = zq[i-1];
      assign ni = nq[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (zi >= 0) begin
          xq[i] <= xi - (yi >>> i);
          yq[i] <= yi + (xi >>> i);
          zq[i] <= zi - atan_q16(i);
        end else begin
          xq[i] <= xi + (yi >>> i);
          yq[i] <= yi - (xi >>> i);
          zq[i] <= zi + atan_q16(i);
        end
        nq[i] <= ni;
      end
    end
  end

  assign trig.c = nq[CORDIC_STEPS-1] ? -xq[CORDIC_STEPS-1] : xq[CORDIC_STEPS-1];
  assign trig.s = nq[CORDIC_STEPS-1] ? -yq[CORDIC_STEPS-1] : yq[CORDIC_STEPS-1];

endmodule

@@ tb/tb_pan_tilt_lidar_point_transform_core.sv @@
// testbench for the pan/tilt lidar point transform with a self-contained point predictor
module tb_pan_tilt_lidar_point_transform_core;
  timeunit 1ns;
  timeprecision 1ps;
  import pta_pkg::*;

  typedef struct {
    logic signed [OW-1:0] x;
    logic signed [OW-1:0] y;
    logic signed [OW-1:0] z;
  } point_t;

  class point_scoreboard;
    logic [15:0] mount [8];
    point_t pending [$];
    int errors;

    function new();
      errors = 0;
      mount[REG_PAN] = 16'd0;
      mount[REG_TILT] = 16'd0;
      mount[REG_INC] = 16'd50;
      mount[REG_START] = 16'(-17154);
      mount[REG_TILT_ARM] = 16'd450;
      mount[REG_PAN_ARM] = 16'd400;
      mount[REG_BASE] = 16'd1140;
      mount[REG_SHIFT] = 16'd285;
    endfunction

    function void set_reg(logic [CIW-1:0] idx, logic [15:0] val);
      if (idx == REG_INC) mount[idx] = {4'd0, val[11:0]};
      else if (idx < 8) mount[idx] = val;
    endfunction

    static function longint floor_shr(longint v, int s);
      return v >>> s;
    endfunction

    static function longint round_shr(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    static function void sincos(longint a, output longint c, output longint s);
      longint x, y, z, nx;
      longint atan_tab [16];
      bit flip;
      atan_tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                   256, 128, 64, 32, 16, 8, 4, 2};
      flip = 0;
      a = a % TWO_PI_Q13;
      if (a < 0) a += TWO_PI_Q13;
      if (a >= PI_Q13) a -= TWO_PI_Q13;
      if (a > HALF_PI_Q13) begin
        a -= PI_Q13;
        flip = 1;
      end else if (a < -HALF_PI_Q13) begin
        a += PI_Q13;
        flip = 1;
      end
      x = CORDIC_X0;
      y = 0;
      z = a * 8;
      for (int i = 0; i < 16; i++) begin
        if (z >= 0) begin
          nx = x - floor_shr(y, i);
          y = y + floor_shr(x, i);
          z -= atan_tab[i];
        end else begin
          nx = x + floor_shr(y, i);
          y = y - floor_shr(x, i);
          z += atan_tab[i];
        end
        x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    static function logic signed [OW-1:0] clamp_round(longint sum, longint off);
      longint v;
      v = round_shr(sum, 32) + off;
      if (v < -1048576) v = -1048576;
      if (v > 1048575) v = 1048575;
      return OW'(v);
    endfunction

    function void note_sample(logic [RW-1:0] rng, logic [IW-1:0] idx);
      longint r, l1, l2, beam, cb, sb, cp, sp, ct, st, xx, yy, yct, sum;
      point_t p;
      r = rng;
      l1 = mount[REG_TILT_ARM];
      l2 = mount[REG_PAN_ARM];
      beam = longint'($signed(mount[REG_START])) + longint'(idx) * longint'(mount[REG_INC]);
      sincos(beam, cb, sb);
      sincos(longint'($signed(mount[REG_PAN])), cp, sp);
      sincos(longint'($signed(mount[REG_TILT])), ct, st);
      xx = r * cb;
      yy = r * sb;
      yct = round_shr(yy * ct, 16);
      sum = xx * cp - yct * sp + round_shr(l1 * sp, 16) * st + l2 * sp * 65536;
      p.x = clamp_round(sum, 0);
      sum = xx * sp + yct * cp - round_shr(l1 * cp, 16) * st + l2 * cp * 65536;
      p.y = clamp_round(sum, -longint'(mount[REG_SHIFT]));
      sum = yy * st + l1 * ct * 65536;
      p.z = clamp_round(sum, longint'(mount[REG_BASE]));
      pending.insert(pending.size(), p);
    endfunction

    function void check_point(logic signed [OW-1:0] x, logic signed [OW-1:0] y,
                              logic signed [OW-1:0] z);
      point_t p;
      if (pending.size() == 0) begin
        $error("unexpected point x=%0d y=%0d z=%0d", x, y, z);
        errors++;
        return;
      end
      p = pending.pop_front();
      if (x !== p.x) begin
        $error("point_x expected %0d actual %0d", p.x, x);
        errors++;
      end
      if (y !== p.y) begin
        $error("point_y expected %0d actual %0d", p.y, y);
        errors++;
      end
      if (z !== p.z) begin
        $error("point_z expected %0d actual %0d", p.z, z);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic [RW-1:0] range_distance;
  logic [IW-1:0] sample_index;
  logic signed [OW-1:0] point_x, point_y, point_z;
  logic [CIW-1:0] cfg_index;
  logic [CW-1:0] cfg_data;
  longint cycles;
  point_scoreboard sb;

  pan_tilt_lidar_point_transform_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .range_distance(range_distance), .sample_index(sample_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 8) return $urandom_range(10, 40);
    if ($urandom_range(0, 99) < 40) return $urandom_range(1, 3);
    return 0;
  endfunction

  // valid stays high into the next transaction when there is no gap
  task automatic send_sample(logic [RW-1:0] rng, logic [IW-1:0] idx, bit with_gaps);
    int g;
    g = with_gaps ? gap_len() : 0;
    cfg_valid <= 1'b0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    range_distance <= rng;
    sample_index <= idx;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(rng, idx);
  endtask

  task automatic write_reg(logic [CIW-1:0] idx, logic [CW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [CW-1:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'(-25736);
      1: return 16'd25736;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 51472) - 25736);
    endcase
  endfunction

  task automatic random_setting();
    write_reg(REG_PAN, rand_angle());
    write_reg(REG_TILT, rand_angle());
    write_reg(REG_INC, CW'($urandom_range(0, 4095)));
    write_reg(REG_START, rand_angle());
    write_reg(REG_TILT_ARM, CW'($urandom));
    write_reg(REG_PAN_ARM, CW'($urandom));
    write_reg(REG_BASE, CW'($urandom));
    write_reg(REG_SHIFT, CW'($urandom));
    if ($urandom_range(0, 1)) write_reg(CIW'($urandom_range(8, 15)), CW'($urandom));
  endtask

  function automatic logic [RW-1:0] rand_range();
    case ($urandom_range(0, 9))
      0: return RW'($urandom);
      1: return RW'($urandom_range(0, 15));
      default: return RW'($urandom_range(0, 600000));
    endcase
  endfunction

  // output side with random back-pressure
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      int g;
      g = gap_len();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if (out_valid && out_ready) sb.check_point(point_x, point_y, point_z);
      while ($urandom_range(0, 3) != 0) begin
        @(posedge clk);
        if (out_valid && out_ready) sb.check_point(point_x, point_y, point_z);
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    range_distance = '0;
    sample_index = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset setting, field extremes, out-of-range range
    send_sample(20'd0, 10'd0, 0);
    send_sample(20'd600000, 10'd1023, 0);
    send_sample(20'hFFFFF, 10'd512, 0);
    send_sample(20'd1, 10'd343, 0);
    send_sample(20'd123456, 10'h2AA, 0);
    send_sample(20'h55555, 10'h155, 0);
    drain();
    write_reg(REG_PAN, 16'd25736);
    write_reg(REG_TILT, 16'(-25736));
    write_reg(REG_INC, 16'd4095);
    write_reg(REG_START, 16'h7FFF);
    write_reg(REG_TILT_ARM, 16'hFFFF);
    write_reg(REG_PAN_ARM, 16'hFFFF);
    write_reg(REG_BASE, 16'hFFFF);
    write_reg(REG_SHIFT, 16'hFFFF);
    write_reg(4'd9, 16'h1234);
    send_sample(20'hFFFFF, 10'd1023, 0);
    send_sample(20'd600000, 10'd0, 0);
    send_sample(20'd0, 10'd777, 0);
    send_sample(20'd300000, 10'd1, 0);
    drain();
    write_reg(REG_PAN, 16'h8000);
    write_reg(REG_TILT, 16'd12868);
    write_reg(REG_INC, 16'd0);
    write_reg(REG_START, 16'(-25736));
    write_reg(REG_TILT_ARM, 16'd0);
    write_reg(REG_PAN_ARM, 16'd0);
    write_reg(REG_BASE, 16'd0);
    write_reg(REG_SHIFT, 16'd0);
    send_sample(20'd600000, 10'd1023, 0);
    send_sample(20'hFFFFF, 10'd5, 0);
    send_sample(20'd42, 10'd0, 0);
    drain();

    // random phases; the drain between them also gives a full sender hold-off
    for (int ph = 0; ph < 10; ph++) begin
      random_setting();
      for (int n = 0; n < 115; n++) send_sample(rand_range(), IW'($urandom), ph % 3 != 0);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
